// ===== hw/rtl/drl_pkg.sv =====
// Shared types and defaults for the dirty region list block.
// No dependencies; the datapath, controller and top files of the block import this package.
package drl_pkg;

    localparam int MAX_REGIONS_DEF = 64;
    localparam int COORD_BITS_DEF  = 16;
    localparam int OUT_COORD_W     = 16;
    localparam int OUT_COUNT_W     = 7;

    typedef enum logic [1:0] {
        OP_APPEND   = 2'd0,
        OP_SUBTRACT = 2'd1,
        OP_READ     = 2'd2,
        OP_CLEAR    = 2'd3
    } t_op;

    // Controller to datapath commands.
    typedef struct packed {
        logic capture;
        logic rd;
        logic pass;
        logic split;
        logic piece;
        logic finish;
        logic append;
        logic clear;
        logic emit_entry;
        logic emit_status;
    } t_drl_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic hit;
        logic rd_done;
        logic pend_empty;
        logic slot_free;
        logic count_zero;
        logic last_entry;
    } t_drl_sts;

endpackage

// ===== hw/rtl/drl_if.sv =====
// Valid/ready channel interfaces for command beats and result beats.
// Depends on nothing; field widths are those of the block's ports.
interface drl_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         op;
    logic signed [15:0] rect_left;
    logic signed [15:0] rect_top;
    logic signed [15:0] rect_right;
    logic signed [15:0] rect_bottom;

    modport source (output valid, op, rect_left, rect_top, rect_right, rect_bottom,
                    input ready);
    modport sink   (input valid, op, rect_left, rect_top, rect_right, rect_bottom,
                    output ready);
endinterface

interface drl_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] out_left;
    logic signed [15:0] out_top;
    logic signed [15:0] out_right;
    logic signed [15:0] out_bottom;
    logic               entry_valid;
    logic               overflow;
    logic [6:0]         entries_now;
    logic               last;

    modport source (output valid, out_left, out_top, out_right, out_bottom, entry_valid,
                    overflow, entries_now, last, input ready);
    modport sink   (input valid, out_left, out_top, out_right, out_bottom, entry_valid,
                    overflow, entries_now, last, output ready);
endinterface

// ===== hw/rtl/drl_datapath.sv =====
// Datapath: double-banked region table, walk counters, piece generation, result register.
// Depends on drl_pkg and drl_out_if.
module drl_datapath #(
    parameter int MAX_REGIONS = drl_pkg::MAX_REGIONS_DEF,
    parameter int COORD_BITS  = drl_pkg::COORD_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  drl_pkg::t_drl_cmd    i_cmd,
    output drl_pkg::t_drl_sts    o_sts,
    input  logic signed [15:0]   i_rect_left,
    input  logic signed [15:0]   i_rect_top,
    input  logic signed [15:0]   i_rect_right,
    input  logic signed [15:0]   i_rect_bottom,
    drl_out_if.source            o_out
);
    import drl_pkg::*;

    localparam int IDX_W = $clog2(MAX_REGIONS);
    localparam int CNT_W = $clog2(MAX_REGIONS + 1);
    localparam int CB    = COORD_BITS;
    localparam int ENT_W = 4 * CB;

    // Two banks, each padded to a power of two so {bank, index} stays in range.
    logic [ENT_W-1:0] mem [2**(IDX_W+1)];

    logic             r_bank;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_rd;
    logic [CNT_W-1:0] r_wr;
    logic             r_ovf;
    logic [3:0]       r_pend;
    logic [ENT_W-1:0] r_rd_data;
    logic [ENT_W-1:0] r_g;
    logic signed [CB-1:0] r_ml, r_mt, r_mr, r_mb;

    logic                          r_o_valid;
    logic signed [OUT_COORD_W-1:0] r_o_l, r_o_t, r_o_r, r_o_b;
    logic                          r_o_ev, r_o_ovf, r_o_last;
    logic [OUT_COUNT_W-1:0]        r_o_cnt;

    logic signed [CB-1:0] dl, dt, dr, db;
    logic signed [CB-1:0] gl, gt, gr, gb, gt2, gb2;
    logic                 overlap, full;
    logic [ENT_W-1:0]     piece;
    logic [3:0]           pend_clr;
    logic                 wr_en;
    logic [IDX_W:0]       wr_addr;
    logic [ENT_W-1:0]     wr_data;
    logic [CNT_W:0]       fill;

    assign dl = r_rd_data[ENT_W-1 -: CB];
    assign dt = r_rd_data[3*CB-1 -: CB];
    assign dr = r_rd_data[2*CB-1 -: CB];
    assign db = r_rd_data[CB-1 -: CB];
    assign gl = r_g[ENT_W-1 -: CB];
    assign gt = r_g[3*CB-1 -: CB];
    assign gr = r_g[2*CB-1 -: CB];
    assign gb = r_g[CB-1 -: CB];

    assign overlap = !(r_mr < dl || r_mb < dt || r_ml > dr || r_mt > db);
    assign gt2     = (gt < r_mt) ? r_mt : gt;
    assign gb2     = (gb > r_mb) ? r_mb : gb;
    assign fill    = {1'b0, r_wr} + {1'b0, r_count} - {1'b0, r_rd};
    assign full    = fill >= (CNT_W+1)'(MAX_REGIONS);

    // Pick the next pending piece: upper, lower, left, right.
    always_comb begin
        priority if (r_pend[0]) begin
            piece    = {gl, gt, gr, CB'(r_mt - 1'b1)};
            pend_clr = 4'b0001;
        end else if (r_pend[1]) begin
            piece    = {gl, CB'(r_mb + 1'b1), gr, gb};
            pend_clr = 4'b0010;
        end else if (r_pend[2]) begin
            piece    = {gl, gt2, CB'(r_ml - 1'b1), gb2};
            pend_clr = 4'b0100;
        end else begin
            piece    = {CB'(r_mr + 1'b1), gt2, gr, gb2};
            pend_clr = 4'b1000;
        end
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = {r_bank, r_count[IDX_W-1:0]};
        wr_data = {r_ml, r_mt, r_mr, r_mb};
        if (i_cmd.append && r_count < CNT_W'(MAX_REGIONS)) begin
            wr_en = 1'b1;
        end else if (i_cmd.pass) begin
            wr_en   = 1'b1;
            wr_addr = {~r_bank, r_wr[IDX_W-1:0]};
            wr_data = r_rd_data;
        end else if (i_cmd.piece && r_pend != 4'd0 && !full) begin
            wr_en   = 1'b1;
            wr_addr = {~r_bank, r_wr[IDX_W-1:0]};
            wr_data = piece;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd) begin
            r_rd_data <= mem[{r_bank, r_rd[IDX_W-1:0]}];
        end
        if (i_cmd.split) begin
            r_g <= r_rd_data;
        end
        if (i_cmd.capture) begin
            r_ml <= i_rect_left[CB-1:0];
            r_mt <= i_rect_top[CB-1:0];
            r_mr <= i_rect_right[CB-1:0];
            r_mb <= i_rect_bottom[CB-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank    <= 1'b0;
            r_count   <= '0;
            r_rd      <= '0;
            r_wr      <= '0;
            r_ovf     <= 1'b0;
            r_pend    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cmd.capture) begin
                r_rd  <= '0;
                r_wr  <= '0;
                r_ovf <= 1'b0;
            end
            if (i_cmd.pass) begin
                r_rd <= r_rd + 1'b1;
                r_wr <= r_wr + 1'b1;
            end
            if (i_cmd.split) begin
                r_rd   <= r_rd + 1'b1;
                r_pend <= {dr > r_mr, dl < r_ml, db > r_mb, dt < r_mt};
            end
            if (i_cmd.piece && r_pend != 4'd0) begin
                if (full) begin
                    r_ovf  <= 1'b1;
                    r_pend <= '0;
                end else begin
                    r_wr   <= r_wr + 1'b1;
                    r_pend <= r_pend & ~pend_clr;
                end
            end
            if (i_cmd.finish) begin
                r_bank  <= ~r_bank;
                r_count <= r_wr;
            end
            if (i_cmd.append) begin
                if (r_count < CNT_W'(MAX_REGIONS)) begin
                    r_count <= r_count + 1'b1;
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            if (i_cmd.clear) begin
                r_count <= '0;
            end
            if (i_cmd.emit_entry) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_cmd.emit_entry || i_cmd.emit_status) begin
                r_o_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Freeze the whole beat, count included, while it waits for the sink.
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_entry) begin
            r_o_l    <= OUT_COORD_W'(dl);
            r_o_t    <= OUT_COORD_W'(dt);
            r_o_r    <= OUT_COORD_W'(dr);
            r_o_b    <= OUT_COORD_W'(db);
            r_o_ev   <= 1'b1;
            r_o_ovf  <= 1'b0;
            r_o_last <= (r_rd + 1'b1) == r_count;
            r_o_cnt  <= OUT_COUNT_W'(r_count);
        end else if (i_cmd.emit_status) begin
            r_o_l    <= '0;
            r_o_t    <= '0;
            r_o_r    <= '0;
            r_o_b    <= '0;
            r_o_ev   <= 1'b0;
            r_o_ovf  <= r_ovf;
            r_o_last <= 1'b1;
            r_o_cnt  <= OUT_COUNT_W'(r_count);
        end
    end

    assign o_sts.hit        = overlap && !r_ovf;
    assign o_sts.rd_done    = r_rd == r_count;
    assign o_sts.pend_empty = r_pend == 4'd0;
    assign o_sts.slot_free  = !r_o_valid || o_out.ready;
    assign o_sts.count_zero = r_count == '0;
    assign o_sts.last_entry = (r_rd + 1'b1) == r_count;

    assign o_out.valid       = r_o_valid;
    assign o_out.out_left    = r_o_l;
    assign o_out.out_top     = r_o_t;
    assign o_out.out_right   = r_o_r;
    assign o_out.out_bottom  = r_o_b;
    assign o_out.entry_valid = r_o_ev;
    assign o_out.overflow    = r_o_ovf;
    assign o_out.entries_now = r_o_cnt;
    assign o_out.last        = r_o_last;

endmodule

// ===== hw/rtl/drl_ctrl.sv =====
// Controller state machine: sequences append, subtract walk, read-out and clear.
// Depends on drl_pkg and drl_in_if.
module drl_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    drl_in_if.sink            i_in,
    input  drl_pkg::t_drl_sts i_sts,
    output drl_pkg::t_drl_cmd o_cmd
);
    import drl_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_APPEND   = 8'b0000_0010,
        S_CLEAR    = 8'b0000_0100,
        S_RD_ISSUE = 8'b0000_1000,
        S_RD_EVAL  = 8'b0001_0000,
        S_PIECE    = 8'b0010_0000,
        S_FINISH   = 8'b0100_0000,
        S_DONE     = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    t_op    r_op, n_op;

    assign i_in.ready = r_state == S_IDLE;

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    o_cmd.capture = 1'b1;
                    n_op          = t_op'(i_in.op);
                    unique case (t_op'(i_in.op))
                        OP_APPEND:   n_state = S_APPEND;
                        OP_SUBTRACT: n_state = S_RD_ISSUE;
                        OP_READ:     n_state = i_sts.count_zero ? S_DONE : S_RD_ISSUE;
                        OP_CLEAR:    n_state = S_CLEAR;
                        default:     n_state = S_IDLE;
                    endcase
                end
            end
            S_APPEND: begin
                o_cmd.append = 1'b1;
                n_state      = S_DONE;
            end
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                n_state     = S_DONE;
            end
            S_RD_ISSUE: begin
                if (i_sts.rd_done) begin
                    n_state = (r_op == OP_SUBTRACT) ? S_FINISH : S_IDLE;
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state  = S_RD_EVAL;
                end
            end
            S_RD_EVAL: begin
                if (r_op == OP_READ) begin
                    if (i_sts.slot_free) begin
                        o_cmd.emit_entry = 1'b1;
                        n_state = i_sts.last_entry ? S_IDLE : S_RD_ISSUE;
                    end
                end else if (i_sts.hit) begin
                    o_cmd.split = 1'b1;
                    n_state     = S_PIECE;
                end else begin
                    o_cmd.pass = 1'b1;
                    n_state    = S_RD_ISSUE;
                end
            end
            S_PIECE: begin
                if (i_sts.pend_empty) begin
                    n_state = S_RD_ISSUE;
                end else begin
                    o_cmd.piece = 1'b1;
                end
            end
            S_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (i_sts.slot_free) begin
                    o_cmd.emit_status = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= OP_APPEND;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
        end
    end

endmodule

// ===== hw/rtl/dirty_region_list_subtract.sv =====
// Dirty region list: an ordered table of up to MAX_REGIONS inclusive rectangles. A command
// beat carries op and a rectangle: append (0) stores it at the end, subtract (1) replaces each
// overlapping entry in place by its upper, lower, left and right pieces, read (2) returns one
// result beat per entry in table order (one empty beat with last set when the table is empty),
// clear (3) empties the table. Append, subtract and clear return one status beat with
// entry_valid low and zero coordinates. When the table fills, an append is dropped and a
// subtract stops adding pieces (the overlapping entry is still removed, later entries are
// kept); either raises overflow for that command only. Coordinates use the low COORD_BITS of
// each field, sign-extended. One command is worked on at a time. The table sits in a memory
// of two banks with one read and one write port; a subtract streams the table from one bank
// to the other. A finished beat waits in an output register while the next command is taken.
// The memory needs no clearing after reset: only entries below the count are read.
module dirty_region_list_subtract #(
    parameter int MAX_REGIONS = drl_pkg::MAX_REGIONS_DEF,
    parameter int COORD_BITS  = drl_pkg::COORD_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    drl_in_if.sink     i_in,
    drl_out_if.source  o_out
);
    import drl_pkg::*;

    t_drl_cmd cmd;
    t_drl_sts sts;

    // Sequence each command beat.
    drl_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // Hold the table, walk it, and drive result beats.
    drl_datapath #(
        .MAX_REGIONS (MAX_REGIONS),
        .COORD_BITS  (COORD_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_rect_left   (i_in.rect_left),
        .i_rect_top    (i_in.rect_top),
        .i_rect_right  (i_in.rect_right),
        .i_rect_bottom (i_in.rect_bottom),
        .o_out         (o_out)
    );

endmodule
